/* design/assert_macros.svh */
// assertion helpers used by lpbd_ctrl
// the enclosing module must have clk and rst in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication or plain check, sampled on clk, off during reset
`define LPBD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check that also holds while reset is high
`define LPBD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/lpbd_pkg.sv */
// ----------------------------------------------------------------------------
// lpbd_pkg
// Types and constants of the lidar point box filter with distance average.
// ----------------------------------------------------------------------------
`default_nettype none

package lpbd_pkg;

  // field widths
  localparam int PointW  = 20;
  localparam int CamW    = 24;
  localparam int CoordW  = CamW + 1;
  localparam int AvgW    = 25;
  localparam int OutCntW = 17;
  localparam int SumW    = 41;
  localparam int RegW    = 64;
  localparam int IdxW    = 3;
  localparam int StepW   = 5;

  // register indexes
  localparam logic [IdxW-1:0] REG_ROW0 = 3'd0;
  localparam logic [IdxW-1:0] REG_ROW1 = 3'd1;
  localparam logic [IdxW-1:0] REG_ROW2 = 3'd2;
  localparam logic [IdxW-1:0] REG_INTR = 3'd3;
  localparam logic [IdxW-1:0] REG_BBOX = 3'd4;

  // reset values: identity rotation, zero translation
  localparam logic [RegW-1:0] ROW0_RST = 64'd8192;
  localparam logic [RegW-1:0] ROW1_RST = 64'd536870912;
  localparam logic [RegW-1:0] ROW2_RST = 64'd35184372088832;

  typedef struct packed {
    logic [2:0][RegW-1:0] row;
    logic [RegW-1:0]      intr;
    logic [RegW-1:0]      bbox;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic             load_point;
    logic             xform_en;
    logic             proj_en;
    logic             sq_en;
    logic             sqrt_init;
    logic             sqrt_en;
    logic             accum;
    logic             div_init;
    logic             div_en;
    logic             out_load;
    logic [StepW-1:0] step;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic accum_ok;
    logic last;
    logic div_early;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

/* design/lpbd_if.sv */
// ----------------------------------------------------------------------------
// lpbd_point_if / lpbd_result_if
// Valid/ready channels for lidar points and per-point results.
// ----------------------------------------------------------------------------
`default_nettype none

interface lpbd_point_if;
  logic              valid;
  logic              ready;
  logic signed [19:0] point_x;
  logic signed [19:0] point_y;
  logic signed [19:0] point_z;
  logic              last_point;

  modport source (output valid, point_x, point_y, point_z, last_point, input ready);
  modport sink   (input valid, point_x, point_y, point_z, last_point, output ready);
endinterface

interface lpbd_result_if;
  logic               valid;
  logic               ready;
  logic               inside_box;
  logic signed [23:0] cam_x;
  logic signed [23:0] cam_y;
  logic signed [23:0] cam_z;
  logic signed [24:0] average_distance;
  logic [16:0]        inside_count;

  modport source (output valid, inside_box, cam_x, cam_y, cam_z, average_distance,
                  inside_count, input ready);
  modport sink   (input valid, inside_box, cam_x, cam_y, cam_z, average_distance,
                  inside_count, output ready);
endinterface

`default_nettype wire

/* design/lpbd_cfg.sv */
// ----------------------------------------------------------------------------
// lpbd_cfg
// Calibration and box register file, write only.
// ----------------------------------------------------------------------------
`default_nettype none

module lpbd_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            we,
  input  logic [lpbd_pkg::IdxW-1:0]       index,
  input  logic [lpbd_pkg::RegW-1:0]       data,
  output lpbd_pkg::cfg_t                  cfg
);
  import lpbd_pkg::*;

  // register writes, unknown indexes dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.row[0] <= ROW0_RST;
      cfg.row[1] <= ROW1_RST;
      cfg.row[2] <= ROW2_RST;
      cfg.intr   <= '0;
      cfg.bbox   <= '0;
    end else if (we) begin
      unique case (index)
        REG_ROW0: cfg.row[0] <= data;
        REG_ROW1: cfg.row[1] <= data;
        REG_ROW2: cfg.row[2] <= data;
        REG_INTR: cfg.intr   <= data;
        REG_BBOX: cfg.bbox   <= data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

/* design/lpbd_dpath.sv */
// ----------------------------------------------------------------------------
// lpbd_dpath
// Shared multiplier, bit-serial square root and divider, accumulators and
// the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lpbd_dpath #(
  parameter int MAX_POINTS = 65536
) (
  input  logic                              clk,
  input  logic                              rst,
  input  lpbd_pkg::cfg_t                    cfg,
  input  lpbd_pkg::cmd_t                    cmd,
  output lpbd_pkg::sts_t                    sts,
  input  logic signed [lpbd_pkg::PointW-1:0] in_x,
  input  logic signed [lpbd_pkg::PointW-1:0] in_y,
  input  logic signed [lpbd_pkg::PointW-1:0] in_z,
  input  logic                              in_last,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_inside,
  output logic signed [lpbd_pkg::CamW-1:0]  out_cam_x,
  output logic signed [lpbd_pkg::CamW-1:0]  out_cam_y,
  output logic signed [lpbd_pkg::CamW-1:0]  out_cam_z,
  output logic signed [lpbd_pkg::AvgW-1:0]  out_avg,
  output logic [lpbd_pkg::OutCntW-1:0]      out_count
);
  import lpbd_pkg::*;

  localparam int CntW   = $clog2(MAX_POINTS + 1);
  localparam int MulW   = 25;
  localparam int ProdW  = 2 * MulW;
  localparam int AccW   = ProdW + 2;
  localparam int RootW  = ProdW / 2;
  localparam int RemW   = RootW + 1;
  localparam int QuotW  = 24;
  localparam int HiW    = SumW - QuotW;
  localparam int CmpW   = HiW + CntW;
  localparam int CmpCW  = CntW + OutCntW;
  localparam int FracB  = 13;

  // point and camera coordinates
  logic signed [PointW-1:0] px, py, pz;
  logic                     last_r;
  logic signed [CoordW-1:0] c [3];

  // multiplier and accumulators
  logic signed [MulW-1:0]  mul_a, mul_b;
  logic signed [ProdW-1:0] prod;
  logic signed [AccW-1:0]  acc, base, acc_new;
  logic signed [ProdW-1:0] proj_num;
  logic                    inside_r;

  // square root
  logic [ProdW-1:0]  rad;
  logic [RemW-1:0]   srem;
  logic [RootW-1:0]  root;
  logic [RemW+1:0]   srem_sh, trial;

  // sum, count, divider
  logic [SumW-1:0]  sum;
  logic [SumW:0]    sum_add;
  logic [CntW-1:0]  count;
  logic [CntW-1:0]  drem;
  logic [CntW:0]    dr2;
  logic [QuotW-1:0] dsh;
  logic [AvgW-1:0]  avg;
  logic             div_over;
  logic [CmpCW-1:0] cnt_wide;

  logic [1:0]        xrow, xcol;
  logic signed [16:0] dx_lo, dx_hi, dy_lo, dy_hi;

  function automatic logic signed [CamW-1:0] sat_cam(input logic signed [CoordW-1:0] v);
    logic signed [CamW-1:0] r;
    if (v[CoordW-1] != v[CamW-1]) r = v[CoordW-1] ? {1'b1, {(CamW-1){1'b0}}}
                                                  : {1'b0, {(CamW-1){1'b1}}};
    else r = v[CamW-1:0];
    return r;
  endfunction

  assign xrow = cmd.step[3:2];
  assign xcol = cmd.step[1:0];

  // box edges relative to the principal point
  assign dx_lo = $signed({1'b0, cfg.bbox[15:0]})  - $signed({1'b0, cfg.intr[47:32]});
  assign dx_hi = $signed({1'b0, cfg.bbox[31:16]}) - $signed({1'b0, cfg.intr[47:32]});
  assign dy_lo = $signed({1'b0, cfg.bbox[47:32]}) - $signed({1'b0, cfg.intr[63:48]});
  assign dy_hi = $signed({1'b0, cfg.bbox[63:48]}) - $signed({1'b0, cfg.intr[63:48]});

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (cmd.xform_en) begin
      mul_a = MulW'($signed(cfg.row[xrow][16*xcol +: 16]));
      unique case (xcol)
        2'd0:    mul_b = MulW'(px);
        2'd1:    mul_b = MulW'(py);
        default: mul_b = MulW'(pz);
      endcase
    end else if (cmd.proj_en) begin
      unique case (cmd.step[2:0])
        3'd0: begin mul_a = MulW'($signed({1'b0, cfg.intr[15:0]}));  mul_b = c[0]; end
        3'd1: begin mul_a = MulW'(dx_lo); mul_b = c[2]; end
        3'd2: begin mul_a = MulW'(dx_hi); mul_b = c[2]; end
        3'd3: begin mul_a = MulW'($signed({1'b0, cfg.intr[31:16]})); mul_b = c[1]; end
        3'd4: begin mul_a = MulW'(dy_lo); mul_b = c[2]; end
        default: begin mul_a = MulW'(dy_hi); mul_b = c[2]; end
      endcase
    end else if (cmd.sq_en) begin
      mul_a = c[cmd.step[1:0]];
      mul_b = c[cmd.step[1:0]];
    end
  end

  assign prod = mul_a * mul_b;

  // transform row base: translation scaled to q13
  always_comb begin
    if (cmd.xform_en) begin
      base = (xcol == 2'd0)
           ? (AccW'($signed(cfg.row[xrow][63:48])) <<< FracB) : acc;
    end else begin
      base = (cmd.step == '0) ? '0 : acc;
    end
  end
  assign acc_new = base + AccW'(prod);

  // transform, projection test and squared norm
  always_ff @(posedge clk) begin
    if (cmd.load_point) begin
      px     <= in_x;
      py     <= in_y;
      pz     <= in_z;
      last_r <= in_last;
    end
    if (cmd.xform_en) begin
      acc <= acc_new;
      if (xcol == 2'd2) c[xrow] <= CoordW'(acc_new >>> FracB);
    end
    if (cmd.sq_en) acc <= acc_new;
    if (cmd.proj_en) begin
      unique case (cmd.step[2:0])
        3'd0: begin proj_num <= prod; inside_r <= (c[2] > 0); end
        3'd1: inside_r <= inside_r && (proj_num >= prod);
        3'd2: inside_r <= inside_r && (proj_num <= prod);
        3'd3: proj_num <= prod;
        3'd4: inside_r <= inside_r && (proj_num >= prod);
        default: inside_r <= inside_r && (proj_num <= prod);
      endcase
    end
  end

  // square root, two radicand bits per step
  assign srem_sh = {srem, rad[ProdW-1 -: 2]};
  assign trial   = (RemW+2)'({root, 2'b01});

  always_ff @(posedge clk) begin
    if (cmd.sqrt_init) begin
      rad  <= acc[ProdW-1:0];
      srem <= '0;
      root <= '0;
    end else if (cmd.sqrt_en) begin
      rad <= rad << 2;
      if (srem_sh >= trial) begin
        srem <= RemW'(srem_sh - trial);
        root <= {root[RootW-2:0], 1'b1};
      end else begin
        srem <= RemW'(srem_sh);
        root <= {root[RootW-2:0], 1'b0};
      end
    end
  end

  // saturating distance sum and count
  assign sum_add  = {1'b0, sum} + (SumW+1)'(root);
  assign div_over = CmpW'(sum[SumW-1:QuotW]) >= CmpW'(count);
  assign dr2      = {drem, dsh[QuotW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      sum   <= '0;
      count <= '0;
    end else if (cmd.out_load && last_r) begin
      sum   <= '0;
      count <= '0;
    end else if (cmd.accum) begin
      sum   <= sum_add[SumW] ? '1 : sum_add[SumW-1:0];
      count <= count + 1'b1;
    end
  end

  // restoring divider, one quotient bit per step
  always_ff @(posedge clk) begin
    if (cmd.load_point) begin
      avg <= '0;
    end else if (cmd.div_init) begin
      drem <= CntW'(sum[SumW-1:QuotW]);
      dsh  <= sum[QuotW-1:0];
      if (count == '0)   avg <= '1;
      else if (div_over) avg <= AvgW'({QuotW{1'b1}});
      else               avg <= '0;
    end else if (cmd.div_en) begin
      dsh <= dsh << 1;
      if (dr2 >= (CntW+1)'(count)) begin
        drem <= CntW'(dr2 - (CntW+1)'(count));
        avg  <= {avg[AvgW-2:0], 1'b1};
      end else begin
        drem <= CntW'(dr2);
        avg  <= {avg[AvgW-2:0], 1'b0};
      end
    end
  end

  // output register
  assign cnt_wide = CmpCW'(count);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_inside <= inside_r;
      out_cam_x  <= sat_cam(c[0]);
      out_cam_y  <= sat_cam(c[1]);
      out_cam_z  <= sat_cam(c[2]);
      out_avg    <= avg;
      out_count  <= (cnt_wide > CmpCW'({OutCntW{1'b1}})) ? '1 : OutCntW'(cnt_wide);
    end
  end

  // status
  assign sts.accum_ok  = inside_r && (count < CntW'(MAX_POINTS));
  assign sts.last      = last_r;
  assign sts.div_early = (count == '0) || div_over;
  assign sts.out_free  = !out_valid || out_ready;

endmodule

`default_nettype wire

/* design/lpbd_ctrl.sv */
// ----------------------------------------------------------------------------
// lpbd_ctrl
// Sequencer: transform, box test, norm, square root, divide, hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module lpbd_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  lpbd_pkg::sts_t sts,
  output lpbd_pkg::cmd_t cmd
);
  import lpbd_pkg::*;

  localparam logic [StepW-1:0] XF_LAST   = 5'b01010;
  localparam logic [StepW-1:0] PROJ_LAST = 5'd5;
  localparam logic [StepW-1:0] SQ_LAST   = 5'd2;
  localparam logic [StepW-1:0] SQRT_LAST = 5'd26;
  localparam logic [StepW-1:0] DIV_LAST  = 5'd24;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_XFORM = 7'b0000010,
    S_PROJ  = 7'b0000100,
    S_SQ    = 7'b0001000,
    S_SQRT  = 7'b0010000,
    S_DIV   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t           state, state_next;
  logic [StepW-1:0] cnt, cnt_next;

  // next state and commands
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.step   = cnt;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_point = 1'b1;
          state_next     = S_XFORM;
          cnt_next       = '0;
        end
      end
      S_XFORM: begin
        cmd.xform_en = 1'b1;
        if (cnt == XF_LAST) begin
          state_next = S_PROJ;
          cnt_next   = '0;
        end else if (cnt[1:0] == 2'd2) begin
          cnt_next = {cnt[4:2] + 3'd1, 2'b00};
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_PROJ: begin
        cmd.proj_en = 1'b1;
        cnt_next    = cnt + 1'b1;
        if (cnt == PROJ_LAST) begin
          state_next = S_SQ;
          cnt_next   = '0;
        end
      end
      S_SQ: begin
        if (!sts.accum_ok) begin
          state_next = sts.last ? S_DIV : S_OUT;
          cnt_next   = '0;
        end else begin
          cmd.sq_en = 1'b1;
          cnt_next  = cnt + 1'b1;
          if (cnt == SQ_LAST) begin
            state_next = S_SQRT;
            cnt_next   = '0;
          end
        end
      end
      S_SQRT: begin
        cnt_next = cnt + 1'b1;
        if (cnt == '0) begin
          cmd.sqrt_init = 1'b1;
        end else if (cnt == SQRT_LAST) begin
          cmd.accum  = 1'b1;
          state_next = sts.last ? S_DIV : S_OUT;
          cnt_next   = '0;
        end else begin
          cmd.sqrt_en = 1'b1;
        end
      end
      S_DIV: begin
        cnt_next = cnt + 1'b1;
        if (cnt == '0) begin
          cmd.div_init = 1'b1;
          if (sts.div_early) state_next = S_OUT;
        end else begin
          cmd.div_en = 1'b1;
          if (cnt == DIV_LAST) state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
        cnt_next   = '0;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // checks
  `LPBD_ASSERT(a_accept_starts, (in_valid && in_ready) |=> (state == S_XFORM), "accepted point did not start transform")
  `LPBD_ASSERT(a_load_when_free, cmd.out_load |-> sts.out_free, "result loaded over an untaken beat")
  `LPBD_ASSERT(a_accum_only_ok, cmd.accum |-> sts.accum_ok, "distance added for a point not counted")

endmodule

`default_nettype wire

/* design/lidar_points_in_box_distance.sv */
// ----------------------------------------------------------------------------
// lidar_points_in_box_distance
// Moves lidar points into the camera frame, tests their projection against
// a pixel box and averages the distance of points inside, per cloud.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                          handshake
//  point    in   point_x, point_y, point_z, last_point            valid/ready
//  result   out  inside_box, cam_x/y/z, average_distance,         valid/ready
//                inside_count
//  cfg      in   cfg_index, cfg_data                              cfg_we
//
// One point is in flight at a time. The 9-step transform and 6-step box
// test run on one shared multiplier; a counted inside point adds the squared
// norm on the same multiplier and a bit-serial square root; the last point
// of a cloud adds a restoring divider, cut short when the count is zero or
// the quotient overflows. The result sits in an output register, so a stalled
// sink holds only the next point's hand-off. Reset is synchronous and
// restores identity calibration.
// ----------------------------------------------------------------------------
`default_nettype none

module lidar_points_in_box_distance #(
  parameter int MAX_POINTS = 65536
) (
  input  logic                          clk,
  input  logic                          rst,
  lpbd_point_if.sink                    point,
  lpbd_result_if.source                 result,
  input  logic                          cfg_we,
  input  logic [lpbd_pkg::IdxW-1:0]     cfg_index,
  input  logic [lpbd_pkg::RegW-1:0]     cfg_data
);
  import lpbd_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  // register file
  lpbd_cfg u_cfg (
    .clk   (clk),
    .rst   (rst),
    .we    (cfg_we),
    .index (cfg_index),
    .data  (cfg_data),
    .cfg   (cfg)
  );

  // sequencer
  lpbd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (point.valid),
    .in_ready (point.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath and output register
  lpbd_dpath #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .cmd        (cmd),
    .sts        (sts),
    .in_x       (point.point_x),
    .in_y       (point.point_y),
    .in_z       (point.point_z),
    .in_last    (point.last_point),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .out_inside (result.inside_box),
    .out_cam_x  (result.cam_x),
    .out_cam_y  (result.cam_y),
    .out_cam_z  (result.cam_z),
    .out_avg    (result.average_distance),
    .out_count  (result.inside_count)
  );

endmodule

`default_nettype wire
